>>> src/calendar_date_seconds_convert_macros.svh
// assertion helpers for the date and seconds converter
`ifndef CALENDAR_DATE_SECONDS_CONVERT_MACROS_SVH
`define CALENDAR_DATE_SECONDS_CONVERT_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define CDSC_ASSERT_NOW(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("converter check failed");

// condition must hold in the cycle after the trigger
`define CDSC_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("converter check failed");

`endif

>>> src/cdsc_pkg.sv
package cdsc_pkg;

    // operation codes
    localparam logic OP_TO_SECONDS = 1'b0;
    localparam logic OP_TO_DATE    = 1'b1;

    // seconds from 1970-01-01 to 2000-01-01
    localparam logic [31:0] SECS_TO_2000 = 32'd946684800;

    // seconds per day split as 2^7 * 675
    localparam int DAY_SHIFT = 7;
    localparam int DAY_ODD   = 675;
    localparam int TOD_X_W   = 32 - DAY_SHIFT;
    localparam int DAYS_W    = 16;
    localparam int DAY_REM_W = 10;
    localparam int YEAR_Q_W  = 8;
    localparam int YEAR_R_W  = 9;
    localparam int DAYS_YEAR = 365;

    typedef struct packed {
        logic        op;
        logic [7:0]  in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [31:0] in_seconds;
    } cdsc_req_t;

    typedef struct packed {
        logic [31:0] out_seconds;
        logic [6:0]  out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
    } cdsc_rsp_t;

    // data that rides along the divider stages
    typedef struct packed {
        logic        op;
        logic [31:0] sec;
    } cdsc_side_t;

    // days before the first of each month, index 0 is january
    function automatic logic [8:0] month_start(input logic [3:0] idx);
        logic [8:0] v;
        begin
            case (idx)
                4'd0:    v = 9'd0;
                4'd1:    v = 9'd31;
                4'd2:    v = 9'd59;
                4'd3:    v = 9'd90;
                4'd4:    v = 9'd120;
                4'd5:    v = 9'd151;
                4'd6:    v = 9'd181;
                4'd7:    v = 9'd212;
                4'd8:    v = 9'd243;
                4'd9:    v = 9'd273;
                4'd10:   v = 9'd304;
                4'd11:   v = 9'd334;
                default: v = 9'd0;
            endcase
            return v;
        end
    endfunction

endpackage

>>> src/cdsc_prep.sv
module cdsc_prep (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                req_valid,
    input  cdsc_pkg::cdsc_req_t req,
    output logic                prep_valid,
    output logic [cdsc_pkg::TOD_X_W-1:0] prep_x,
    output cdsc_pkg::cdsc_side_t prep_side
);
    import cdsc_pkg::*;

    logic [3:0]          month_c;
    logic [6:0]          leaps;
    logic                leap_fix;
    logic signed [10:0]  day_part;
    logic [16:0]         year_days;
    logic signed [18:0]  tdays_next;
    logic [31:0]         since_2000;
    logic [TOD_X_W-1:0]  x_next;

    logic                v1_reg;
    logic                op1_reg;
    logic signed [18:0]  tdays_reg;
    logic [TOD_X_W-1:0]  x1_reg;

    logic                v2_reg;
    logic [TOD_X_W-1:0]  x2_reg;
    cdsc_side_t          side2_reg;
    logic signed [37:0]  prod;

    // day count since 2000 for a date, and the seconds since 2000 prescaled by 2^7 for a count
    always_comb
    begin
        if (req.in_month == 4'd0)
            month_c = 4'd1;
        else if (req.in_month > 4'd12)
            month_c = 4'd12;
        else
            month_c = req.in_month;
        leaps     = 7'(({1'b0, req.in_year} + 9'd3) >> 2);
        leap_fix  = (req.in_year[1:0] == 2'b00) && (month_c > 4'd2);
        day_part  = $signed({4'b0, leaps}) + $signed({2'b0, month_start(month_c - 4'd1)})
                  + $signed({10'b0, leap_fix}) + $signed({6'b0, req.in_day}) - 11'sd1;
        year_days = {9'b0, req.in_year} * 17'd365;
        tdays_next = $signed({2'b0, year_days}) + $signed({{8{day_part[10]}}, day_part});
        since_2000 = (req.in_seconds > SECS_TO_2000) ? (req.in_seconds - SECS_TO_2000) : 32'd0;
        x_next     = since_2000[31:DAY_SHIFT];
    end

    // first stage: day count and prescaled seconds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg   <= req.op;
            tdays_reg <= tdays_next;
            x1_reg    <= x_next;
        end
    end

    // second stage: days times seconds per day, low word kept
    assign prod = tdays_reg * 19'sd86400;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg        <= x1_reg;
            side2_reg.op  <= op1_reg;
            side2_reg.sec <= prod[31:0];
        end
    end

    assign prep_valid = v2_reg;
    assign prep_x     = x2_reg;
    assign prep_side  = side2_reg;

endmodule

>>> src/cdsc_cdiv.sv
// divide by a constant: reciprocal multiply, back-multiply, one correction step
module cdsc_cdiv #(
    parameter int XW  = 25,
    parameter int D   = 675,
    parameter int SH  = 32,
    parameter int QW  = 16,
    parameter int RW  = 10,
    parameter int SBW = 33
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           x_valid,
    input  logic [XW-1:0]  x,
    input  logic [SBW-1:0] side_in,
    output logic           q_valid,
    output logic [QW-1:0]  q,
    output logic [RW-1:0]  rem,
    output logic [SBW-1:0] side_out
);
    localparam longint unsigned MULT = (64'd1 << SH) / D;
    localparam int MW = $clog2(MULT + 1);
    localparam int PW = XW + MW;
    localparam int DW = $clog2(D + 1);
    localparam int TW = QW + DW;

    logic           va_reg, vb_reg, vc_reg;
    logic [PW-1:0]  p_reg;
    logic [XW-1:0]  xa_reg, xb_reg;
    logic [SBW-1:0] sa_reg, sb_reg, sc_reg;
    logic [QW-1:0]  q0;
    logic [QW-1:0]  q0_reg;
    logic [TW-1:0]  t_reg;
    logic [XW-1:0]  diff;
    logic [QW-1:0]  q_next, q_reg;
    logic [RW-1:0]  r_next, r_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= x_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    // estimate is exact or one low
    assign q0 = p_reg[SH +: QW];

    // remainder correction
    always_comb
    begin
        diff = xb_reg - XW'(t_reg);
        if (diff >= XW'(D))
        begin
            q_next = q0_reg + QW'(1);
            r_next = RW'(diff - XW'(D));
        end
        else
        begin
            q_next = q0_reg;
            r_next = RW'(diff);
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg  <= PW'(x) * PW'(MULT);
            xa_reg <= x;
            sa_reg <= side_in;
            t_reg  <= TW'(q0) * TW'(D);
            q0_reg <= q0;
            xb_reg <= xa_reg;
            sb_reg <= sa_reg;
            q_reg  <= q_next;
            r_reg  <= r_next;
            sc_reg <= sb_reg;
        end
    end

    assign q_valid  = vc_reg;
    assign q        = q_reg;
    assign rem      = r_reg;
    assign side_out = sc_reg;

endmodule

>>> src/cdsc_cal.sv
module cdsc_cal (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 yr_valid,
    input  logic [cdsc_pkg::YEAR_Q_W-1:0] yr,
    input  logic [cdsc_pkg::YEAR_R_W-1:0] yday,
    input  cdsc_pkg::cdsc_side_t side,
    output logic                 rsp_valid,
    output cdsc_pkg::cdsc_rsp_t  rsp
);
    import cdsc_pkg::*;

    logic [6:0]         leaps;
    logic signed [10:0] dn0;
    logic [YEAR_Q_W-1:0] yr_prev;
    logic [6:0]         yr_next;
    logic signed [10:0] dn_next;

    logic               va_reg;
    logic [6:0]         yr_reg;
    logic signed [9:0]  dn_reg;
    cdsc_side_t         side_reg;

    logic               lp;
    logic [9:0]         lim;
    logic [3:0]         mon;
    logic [9:0]         base;
    logic [4:0]         day;

    logic               vb_reg;
    cdsc_rsp_t          rsp_reg;

    // day of year, borrowing from the year before when leap days push it under one
    always_comb
    begin
        leaps   = 7'(({1'b0, yr} + 9'd3) >> 2);
        dn0     = $signed({2'b0, yday}) + 11'sd1 - $signed({4'b0, leaps});
        yr_prev = yr - YEAR_Q_W'(1);
        if ((dn0 <= 11'sd0) && (yr != '0))
        begin
            yr_next = 7'(yr_prev);
            dn_next = dn0 + ((yr_prev[1:0] == 2'b00) ? 11'sd366 : 11'sd365);
        end
        else
        begin
            yr_next = 7'(yr);
            dn_next = dn0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (en)
            va_reg <= yr_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yr_reg   <= yr_next;
            dn_reg   <= 10'(dn_next);
            side_reg <= side;
        end
    end

    // month search over the month starts, then day within the month
    always_comb
    begin
        lp  = (yr_reg[1:0] == 2'b00);
        mon = 4'd12;
        lim = '0;
        for (int i = 11; i >= 1; i--)
        begin
            lim = {1'b0, month_start(4'(i))} + {9'b0, (lp && (i >= 2))};
            if ($signed({1'b0, lim}) >= $signed({dn_reg[9], dn_reg}))
                mon = 4'(i);
        end
        base = {1'b0, month_start(mon - 4'd1)} + {9'b0, (lp && (mon > 4'd2))};
        day  = 5'(dn_reg - $signed(base));
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (en)
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (side_reg.op == OP_TO_DATE)
            begin
                rsp_reg.out_seconds <= 32'd0;
                rsp_reg.out_year    <= yr_reg;
                rsp_reg.out_month   <= mon;
                rsp_reg.out_day     <= day;
            end
            else
            begin
                rsp_reg.out_seconds <= side_reg.sec + SECS_TO_2000;
                rsp_reg.out_year    <= 7'd0;
                rsp_reg.out_month   <= 4'd0;
                rsp_reg.out_day     <= 5'd0;
            end
        end
    end

    assign rsp_valid = vb_reg;
    assign rsp       = rsp_reg;

endmodule

>>> src/calendar_date_seconds_convert.sv
// Calendar date <-> seconds since 1970-01-01 converter.
// Request channel req_valid/req_ready/req carries op, date fields and seconds;
// op 0 turns (year since 2000, month, day) into seconds at midnight, op 1
// turns seconds into year, month and day (times before 2000 give 2000-01-01).
// Response channel rsp_valid/rsp_ready/rsp carries one result per request,
// in request order; fields not used by the op read as zero.
// A request passes through two preparation stages, three stages dividing
// by seconds per day, three stages dividing by days per year, and two
// calendar stages on its way to the response.
// Throughput is one transaction per cycle; the pipeline is fully stalled
// together, so req_ready is low only while a response waits and rsp_ready
// is low. A stall holds every stage, losing and repeating nothing.
// Reset clears all valid bits; the block keeps no other state and is ready
// right after reset.
`include "calendar_date_seconds_convert_macros.svh"

module calendar_date_seconds_convert (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  cdsc_pkg::cdsc_req_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output cdsc_pkg::cdsc_rsp_t rsp
);
    import cdsc_pkg::*;

    logic                  en;
    logic                  prep_valid;
    logic [TOD_X_W-1:0]    prep_x;
    cdsc_side_t            prep_side;

    logic                  days_valid;
    logic [DAYS_W-1:0]     days;
    logic [DAY_REM_W-1:0]  days_rem;
    logic [$bits(cdsc_side_t)-1:0] days_side;

    logic                  yr_valid;
    logic [YEAR_Q_W-1:0]   yr;
    logic [YEAR_R_W-1:0]   yday;
    logic [$bits(cdsc_side_t)-1:0] yr_side;

    // whole pipeline advances unless a response is held
    assign en        = !rsp_valid || rsp_ready;
    assign req_ready = en;

    cdsc_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .req_valid  (req_valid),
        .req        (req),
        .prep_valid (prep_valid),
        .prep_x     (prep_x),
        .prep_side  (prep_side)
    );

    // seconds since 2000 divided by 86400, prescaled by 2^7
    cdsc_cdiv #(
        .XW  (TOD_X_W),
        .D   (DAY_ODD),
        .SH  (32),
        .QW  (DAYS_W),
        .RW  (DAY_REM_W),
        .SBW ($bits(cdsc_side_t))
    ) u_day_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .x_valid  (prep_valid),
        .x        (prep_x),
        .side_in  (prep_side),
        .q_valid  (days_valid),
        .q        (days),
        .rem      (days_rem),
        .side_out (days_side)
    );

    // days divided by 365
    cdsc_cdiv #(
        .XW  (DAYS_W),
        .D   (DAYS_YEAR),
        .SH  (24),
        .QW  (YEAR_Q_W),
        .RW  (YEAR_R_W),
        .SBW ($bits(cdsc_side_t))
    ) u_year_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .x_valid  (days_valid),
        .x        (days),
        .side_in  (days_side),
        .q_valid  (yr_valid),
        .q        (yr),
        .rem      (yday),
        .side_out (yr_side)
    );

    cdsc_cal u_cal (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .yr_valid  (yr_valid),
        .yr        (yr),
        .yday      (yday),
        .side      (cdsc_side_t'(yr_side)),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    // the time-of-day remainder is within one day
    `CDSC_ASSERT_NOW(a_day_rem, days_valid, days_rem < DAY_REM_W'(DAY_ODD))

    // only the fields of one op are ever nonzero
    `CDSC_ASSERT_NOW(a_unused_zero, rsp_valid, (rsp.out_seconds == 32'd0) || ((rsp.out_year == 7'd0) && (rsp.out_month == 4'd0) && (rsp.out_day == 5'd0)))

    // decoded dates stay on the calendar
    `CDSC_ASSERT_NOW(a_date_range, rsp_valid && (rsp.out_month != 4'd0), (rsp.out_month <= 4'd12) && (rsp.out_day != 5'd0) && (rsp.out_year <= 7'd106))

    // an empty output stage never blocks requests
    `CDSC_ASSERT_NOW(a_no_block, !rsp_valid, req_ready)

endmodule
